>>> design/egg_drop_min_trials_top_assert.svh
// Assertion macros shared by the checker of the egg drop block.
`ifndef EGG_DROP_MIN_TRIALS_TOP_ASSERT_SVH
`define EGG_DROP_MIN_TRIALS_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define EDMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("egg drop assertion failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define EDMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("egg drop assertion failed");

`endif

>>> design/edmt_pkg.sv
// Package with the constants, payload types, control structs and table address function of the egg drop block.
`default_nettype none
package edmt_pkg;

  localparam int MAX_EGGS   = 8;
  localparam int MAX_FLOORS = 255;
  localparam int ROW_LEN    = MAX_FLOORS + 1;
  localparam int DEPTH      = MAX_EGGS * ROW_LEN;

  localparam int EGGS_IN_W   = 4;
  localparam int FLOORS_IN_W = 8;
  localparam int DROP_W      = 8;

  localparam int EGG_W     = $clog2(MAX_EGGS);
  localparam int EGG_CNT_W = $clog2(MAX_EGGS + 1);
  localparam int FLOOR_W   = $clog2(MAX_FLOORS + 1);
  localparam int BEST_W    = FLOOR_W + 1;
  localparam int ADDR_W    = $clog2(DEPTH);

  typedef struct packed {
    logic [EGGS_IN_W-1:0]   eggs;
    logic [FLOORS_IN_W-1:0] floors;
  } in_t;

  typedef struct packed {
    logic [DROP_W-1:0] min_drops;
    logic              invalid;
  } out_t;

  typedef struct packed {
    logic load;
    logic reject;
    logic init;
    logic issue;
    logic write;
    logic next_floor;
    logic next_egg;
  } dp_cmd_t;

  typedef struct packed {
    logic query_invalid;
    logic need_loop;
    logic x_last;
    logic last_floor;
    logic last_egg;
  } dp_sts_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [EGG_W-1:0] row,
                                                  input logic [FLOOR_W-1:0] fl);
    cell_addr = ADDR_W'(row) * ADDR_W'(ROW_LEN) + ADDR_W'(fl);
  endfunction

endpackage
`default_nettype wire

>>> design/egg_drop_min_trials_top.sv
// Top level of the egg drop block: least worst-case drop count per query.
//
// A query transfers at a rising edge with start high and busy low; in_data carries the
// egg count and the floor count. Each query gives one result, shown on out_data for one
// cycle with out_valid high; the receiver cannot stall, so it must take it then.
// A query with zero eggs or more than MAX_EGGS eggs is answered in the cycle after its
// transfer with invalid set and zero drops, and busy stays low.
// A valid query with E eggs and F floors fills the drop table row by row in a single-port
// write, dual-port read memory. In row one, and at floor zero of every row, each floor
// passes through the floor state and one write. In every later row floor f issues one
// read pair per candidate drop floor, then a drain state for the registered read, then
// one write. The result strobe follows in the cycle after the last write. Busy is high
// from the transfer until the result strobe; a new query may transfer in the strobe
// cycle. Synchronous reset returns the controller to idle; the table keeps no reset
// value, since every entry is written in a query before it is read.
`default_nettype none
module egg_drop_min_trials_top (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire edmt_pkg::in_t  in_data,
  output logic                busy,
  output logic                out_valid,
  output edmt_pkg::out_t      out_data
);

  edmt_pkg::dp_cmd_t cmd;
  edmt_pkg::dp_sts_t sts;

  edmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  edmt_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .res     (out_data)
  );

endmodule
`default_nettype wire

>>> design/edmt_dp.sv
// Datapath of the egg drop block: table memory, loop counters and running minimum.
`default_nettype none
module edmt_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire edmt_pkg::in_t     in_data,
  input  wire edmt_pkg::dp_cmd_t cmd,
  output edmt_pkg::dp_sts_t      sts,
  output edmt_pkg::out_t         res
);

  logic [edmt_pkg::DROP_W-1:0]    mem [edmt_pkg::DEPTH];
  logic [edmt_pkg::EGG_CNT_W-1:0] egg_q_r;
  logic [edmt_pkg::FLOOR_W-1:0]   floor_q_r;
  logic [edmt_pkg::EGG_CNT_W-1:0] e_r;
  logic [edmt_pkg::FLOOR_W-1:0]   f_r;
  logic [edmt_pkg::FLOOR_W-1:0]   x_r;
  logic [edmt_pkg::BEST_W-1:0]    best_r;
  logic [edmt_pkg::DROP_W-1:0]    rd_a_r;
  logic [edmt_pkg::DROP_W-1:0]    rd_b_r;
  logic                           cmp_vld_r;
  edmt_pkg::out_t                 res_r;

  logic [edmt_pkg::FLOOR_W-1:0]   floor_sat;
  logic [edmt_pkg::ADDR_W-1:0]    addr_a;
  logic [edmt_pkg::ADDR_W-1:0]    addr_b;
  logic [edmt_pkg::ADDR_W-1:0]    addr_w;
  logic [edmt_pkg::DROP_W-1:0]    worst;
  logic [edmt_pkg::DROP_W-1:0]    wr_val;

  always_comb begin
    if (32'(in_data.floors) > edmt_pkg::MAX_FLOORS) begin
      floor_sat = edmt_pkg::FLOOR_W'(edmt_pkg::MAX_FLOORS);
    end else begin
      floor_sat = edmt_pkg::FLOOR_W'(in_data.floors);
    end
  end

  assign sts.query_invalid = (in_data.eggs == '0) ||
                             (32'(in_data.eggs) > edmt_pkg::MAX_EGGS);
  assign sts.need_loop  = (f_r != '0) && (e_r != edmt_pkg::EGG_CNT_W'(1));
  assign sts.x_last     = (x_r == f_r);
  assign sts.last_floor = (f_r == floor_q_r);
  assign sts.last_egg   = (e_r == egg_q_r);

  assign addr_a = edmt_pkg::cell_addr(edmt_pkg::EGG_W'(e_r - 1'b1), f_r - x_r);
  assign addr_b = edmt_pkg::cell_addr(edmt_pkg::EGG_W'(e_r - 2'd2), x_r - 1'b1);
  assign addr_w = edmt_pkg::cell_addr(edmt_pkg::EGG_W'(e_r - 1'b1), f_r);

  assign worst = (rd_a_r > rd_b_r) ? rd_a_r : rd_b_r;

  always_comb begin
    if (f_r == '0) begin
      wr_val = '0;
    end else if (e_r == edmt_pkg::EGG_CNT_W'(1)) begin
      wr_val = edmt_pkg::DROP_W'(f_r);
    end else begin
      wr_val = edmt_pkg::DROP_W'(best_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[addr_w] <= wr_val;
    end
    if (cmd.issue) begin
      rd_a_r <= mem[addr_a];
      rd_b_r <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      egg_q_r   <= edmt_pkg::EGG_CNT_W'(in_data.eggs);
      floor_q_r <= floor_sat;
      e_r       <= edmt_pkg::EGG_CNT_W'(1);
      f_r       <= '0;
    end else if (cmd.next_egg) begin
      e_r <= e_r + 1'b1;
      f_r <= '0;
    end else if (cmd.next_floor) begin
      f_r <= f_r + 1'b1;
    end
    if (cmd.init) begin
      x_r    <= edmt_pkg::FLOOR_W'(1);
      best_r <= edmt_pkg::BEST_W'(f_r) + 1'b1;
    end else begin
      if (cmd.issue) begin
        x_r <= x_r + 1'b1;
      end
      if (cmp_vld_r && ({1'b0, worst} < best_r)) begin
        best_r <= edmt_pkg::BEST_W'(worst);
      end
    end
    if (cmd.reject) begin
      res_r.min_drops <= '0;
      res_r.invalid   <= 1'b1;
    end else if (cmd.write) begin
      res_r.min_drops <= wr_val;
      res_r.invalid   <= 1'b0;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

>>> design/edmt_ctrl.sv
// Controller state machine of the egg drop block.
`default_nettype none
module edmt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire edmt_pkg::dp_sts_t sts,
  output edmt_pkg::dp_cmd_t      cmd,
  output logic                   busy,
  output logic                   out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FLOOR,
    S_ISSUE,
    S_DRAIN,
    S_WRITE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign accept = start && !busy_r;

  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (sts.query_invalid) begin
            cmd.reject    = 1'b1;
            out_valid_nxt = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            busy_nxt  = 1'b1;
            state_nxt = S_FLOOR;
          end
        end
      end
      S_FLOOR: begin
        if (sts.need_loop) begin
          cmd.init  = 1'b1;
          state_nxt = S_ISSUE;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (sts.x_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        if (!sts.last_floor) begin
          cmd.next_floor = 1'b1;
          state_nxt      = S_FLOOR;
        end else if (!sts.last_egg) begin
          cmd.next_egg = 1'b1;
          state_nxt    = S_FLOOR;
        end else begin
          out_valid_nxt = 1'b1;
          busy_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> design/edmt_checker.sv
// Port-level checker of the egg drop block and its bind to the top level.
`default_nettype none
`include "egg_drop_min_trials_top_assert.svh"
module edmt_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           start,
  input wire edmt_pkg::in_t  in_data,
  input wire logic           busy,
  input wire logic           out_valid,
  input wire edmt_pkg::out_t out_data
);

  logic bad_eggs;
  logic take;

  assign bad_eggs = (in_data.eggs == '0) || (32'(in_data.eggs) > edmt_pkg::MAX_EGGS);
  assign take     = start && !busy;

  `EDMT_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_valid && out_data.invalid, out_data.min_drops == '0)
  `EDMT_ASSERT_NEXT(a_reject_fast, clk, rst_n, take && bad_eggs, out_valid && out_data.invalid && !busy)
  `EDMT_ASSERT_NEXT(a_valid_busy, clk, rst_n, take && !bad_eggs, busy && !out_valid)
  `EDMT_ASSERT_NOW(a_no_result_busy, clk, rst_n, busy, !out_valid)

endmodule

bind egg_drop_min_trials_top edmt_checker u_edmt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .in_data   (in_data),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
